### sv/csvt_pkg.sv
// Shared types and constants for the CSV record tokenizer.
`timescale 1ns / 1ps
package csvt_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam int unsigned OutPosBits = 24;
  localparam int unsigned CountBits  = 25;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  localparam logic [7:0]  DelimiterReset = CH_COMMA;
  localparam logic [23:0] MaxBytesReset  = 24'hFFFFFF;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_DELIMITER = 1'b0,
    REG_MAX_BYTES = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_AFTER_QUOTE = 3'd1,
    ERR_OPEN_QUOTE  = 3'd2,
    ERR_EMPTY       = 3'd3,
    ERR_TOO_LONG    = 3'd4,
    ERR_BAD_DELIM   = 3'd5
  } err_code_e;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       doc_last;
  } item_t;

  typedef struct packed {
    logic                  content_valid;
    logic [7:0]            content_byte;
    logic                  field_end;
    logic                  record_end;
    logic                  doc_done;
    err_code_e             error_code;
    logic [OutPosBits-1:0] field_line;
    logic [OutPosBits-1:0] field_column;
    logic [OutPosBits-1:0] error_line;
    logic [OutPosBits-1:0] error_column;
  } result_t;

  typedef struct packed {
    logic [7:0]  delimiter;
    logic [23:0] max_document_bytes;
  } cfg_t;

endpackage

### sv/csv_record_tokenizer_top.sv
// Top level of the CSV record tokenizer: stream ports, input and result registers.
`timescale 1ns / 1ps
// Usage:
//   Input stream: one document byte per transfer. s_axis_tdata carries the byte,
//   s_axis_tuser says whether the byte is present (0 = bare end item), and
//   s_axis_tlast closes the document and flushes the last field and record.
//   Output stream: exactly one result transfer per input transfer, in order.
//   m_axis_tuser carries content_valid, field_end and record_end; m_axis_tlast
//   marks the result of the document's last item; m_axis_tdata carries the
//   content byte, the error code and the field start and current positions.
//   Configuration: APB port, delimiter at address 0, byte limit at address 4;
//   write them only while no transfer is in flight.
// Timing: an input transfer is held in the input register, the parser updates
//   its state and forms the result combinationally, and the result register
//   captures it, so the result transfer follows the input transfer through
//   these two registers. Throughput is one item per cycle while m_axis_tready
//   is high, set by the parser's per-item state update.
// Stall: while m_axis_tready is low the result is held and the input register
//   still takes one more item; after that s_axis_tready drops until the
//   result is taken.
// Reset: rst_ni clears both valid flags and the parser state and restores the
//   default delimiter (comma) and the largest byte limit.
module csv_record_tokenizer_top #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // slave stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic          s_axis_tuser,   // [0] has_byte
  input  logic          s_axis_tlast,   // doc_last
  // master stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [7:0] content_byte, [10:8] error_code, [34:11] field_line, [58:35] field_column,
  // [82:59] error_line, [106:83] error_column, [111:107] zero
  output logic [111:0]  m_axis_tdata,
  output logic [2:0]    m_axis_tuser,   // [0] content_valid, [1] field_end, [2] record_end
  output logic          m_axis_tlast,   // doc_done
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import csvt_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q, out_valid_q;
  logic    advance;
  result_t result, result_q;

  csvt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move the held item into the result register when that slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.has_byte  <= s_axis_tuser;
      item_q.data_byte <= s_axis_tdata;
      item_q.doc_last  <= s_axis_tlast;
    end
  end

  csvt_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, result_q.error_column, result_q.error_line,
                          result_q.field_column, result_q.field_line,
                          result_q.error_code, result_q.content_byte};
  assign m_axis_tuser  = {result_q.record_end, result_q.field_end, result_q.content_valid};
  assign m_axis_tlast  = result_q.doc_done;

endmodule

### sv/csvt_cfg.sv
// APB register file: delimiter and document byte limit.
`timescale 1ns / 1ps
module csvt_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output csvt_pkg::cfg_t cfg_o
);
  import csvt_pkg::*;

  logic [7:0]  delimiter_q;
  logic [23:0] max_bytes_q;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delimiter_q <= DelimiterReset;
      max_bytes_q <= MaxBytesReset;
    end else if (wr_en) begin
      case (idx)
        REG_DELIMITER: delimiter_q <= pwdata[7:0];
        REG_MAX_BYTES: max_bytes_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELIMITER: prdata = {24'd0, delimiter_q};
      REG_MAX_BYTES: prdata = {8'd0, max_bytes_q};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o.delimiter          = delimiter_q;
  assign cfg_o.max_document_bytes = max_bytes_q;

endmodule

### sv/csvt_parser.sv
// Parser state registers and the combinational per-item state update.
`timescale 1ns / 1ps
module csvt_parser #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  csvt_pkg::item_t   item_i,
  input  csvt_pkg::cfg_t    cfg_i,
  output csvt_pkg::result_t result_o
);
  import csvt_pkg::*;

  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

  typedef struct packed {
    logic                     in_quotes;
    logic                     quote_pending;
    logic                     after_quote;
    logic                     skip_linefeed;
    logic                     field_has_chars;
    logic                     record_open;
    logic                     error_stuck;
    err_code_e                stuck_code;
    logic [POSITION_BITS-1:0] cur_line;
    logic [POSITION_BITS-1:0] cur_col;
    logic [POSITION_BITS-1:0] start_line;
    logic [POSITION_BITS-1:0] start_col;
    logic [CountBits-1:0]     byte_count;
  } pstate_t;

  localparam pstate_t StateReset = '{
    in_quotes: 1'b0, quote_pending: 1'b0, after_quote: 1'b0, skip_linefeed: 1'b0,
    field_has_chars: 1'b0, record_open: 1'b0, error_stuck: 1'b0,
    stuck_code: ERR_NONE, cur_line: PosOne, cur_col: PosOne,
    start_line: PosOne, start_col: PosOne, byte_count: '0
  };

  pstate_t st_q, st_d;

  logic [7:0]               c;
  logic                     nl, skip, handled, bad_delim;
  logic                     cv, fe, re;
  logic [7:0]               cb;
  logic [CountBits-1:0]     cnt_inc;
  logic [POSITION_BITS-1:0] fl, fc, el, ec;

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d      = st_q;
    c         = item_i.data_byte;
    nl        = (c == CH_LF) || (c == CH_CR);
    skip      = 1'b0;
    handled   = 1'b0;
    cv        = 1'b0;
    cb        = 8'd0;
    fe        = 1'b0;
    re        = 1'b0;
    cnt_inc   = (st_q.byte_count < CountMax) ? st_q.byte_count + 1'b1 : st_q.byte_count;
    bad_delim = (cfg_i.delimiter == CH_LF) || (cfg_i.delimiter == CH_CR) ||
                (cfg_i.delimiter == CH_QUOTE);

    // Delimiter check runs before everything else
    if (!st_d.error_stuck && bad_delim) begin
      st_d.error_stuck = 1'b1;
      st_d.stuck_code  = ERR_BAD_DELIM;
    end

    if (item_i.has_byte && !st_d.error_stuck) begin
      st_d.byte_count = cnt_inc;
      if (cnt_inc > {1'b0, cfg_i.max_document_bytes}) begin
        st_d.error_stuck = 1'b1;
        st_d.stuck_code  = ERR_TOO_LONG;
      end else begin
        // Drop the LF of a CRLF pair
        if (st_d.skip_linefeed) begin
          st_d.skip_linefeed = 1'b0;
          skip = (c == CH_LF);
        end
        if (!skip) begin
          if (st_d.in_quotes) begin
            if (st_d.quote_pending) begin
              st_d.quote_pending = 1'b0;
              if (c == CH_QUOTE) begin
                cv = 1'b1;
                cb = CH_QUOTE;
                st_d.field_has_chars = 1'b1;
                st_d.cur_col = sat_inc(st_d.cur_col);
                handled = 1'b1;
              end else begin
                // Held quote closed the field; reparse byte as after-quote
                st_d.in_quotes   = 1'b0;
                st_d.after_quote = 1'b1;
              end
            end else if (c == CH_QUOTE) begin
              st_d.quote_pending = 1'b1;
              st_d.cur_col = sat_inc(st_d.cur_col);
              handled = 1'b1;
            end else begin
              cv = 1'b1;
              cb = c;
              st_d.field_has_chars = 1'b1;
              if (nl) begin
                st_d.cur_line = sat_inc(st_d.cur_line);
                st_d.cur_col  = PosOne;
                if (c == CH_CR) st_d.skip_linefeed = 1'b1;
              end else begin
                st_d.cur_col = sat_inc(st_d.cur_col);
              end
              handled = 1'b1;
            end
          end

          if (!handled) begin
            if (st_d.after_quote) begin
              if (c == cfg_i.delimiter) begin
                st_d.after_quote = 1'b0;
                fe = 1'b1;
                st_d.cur_col = sat_inc(st_d.cur_col);
                st_d.start_line = st_d.cur_line;
                st_d.start_col  = st_d.cur_col;
                st_d.field_has_chars = 1'b0;
              end else if (nl) begin
                st_d.after_quote = 1'b0;
                fe = 1'b1;
                re = 1'b1;
                st_d.record_open = 1'b0;
                st_d.cur_line = sat_inc(st_d.cur_line);
                st_d.cur_col  = PosOne;
                if (c == CH_CR) st_d.skip_linefeed = 1'b1;
                st_d.start_line = st_d.cur_line;
                st_d.start_col  = st_d.cur_col;
                st_d.field_has_chars = 1'b0;
              end else begin
                st_d.error_stuck = 1'b1;
                st_d.stuck_code  = ERR_AFTER_QUOTE;
              end
            end else if (c == CH_QUOTE && !st_d.field_has_chars) begin
              st_d.in_quotes   = 1'b1;
              st_d.record_open = 1'b1;
              st_d.cur_col = sat_inc(st_d.cur_col);
            end else if (c == cfg_i.delimiter) begin
              fe = 1'b1;
              st_d.record_open = 1'b1;
              st_d.cur_col = sat_inc(st_d.cur_col);
              st_d.start_line = st_d.cur_line;
              st_d.start_col  = st_d.cur_col;
              st_d.field_has_chars = 1'b0;
            end else if (nl) begin
              fe = 1'b1;
              re = 1'b1;
              st_d.record_open = 1'b0;
              st_d.cur_line = sat_inc(st_d.cur_line);
              st_d.cur_col  = PosOne;
              if (c == CH_CR) st_d.skip_linefeed = 1'b1;
              st_d.start_line = st_d.cur_line;
              st_d.start_col  = st_d.cur_col;
              st_d.field_has_chars = 1'b0;
            end else begin
              cv = 1'b1;
              cb = c;
              st_d.field_has_chars = 1'b1;
              st_d.record_open = 1'b1;
              st_d.cur_col = sat_inc(st_d.cur_col);
            end
          end
        end
      end
    end

    // End of document: flag an empty document, flush the open field or flag an open quote
    if (item_i.doc_last && !st_d.error_stuck) begin
      if (st_d.byte_count == '0) begin
        st_d.error_stuck = 1'b1;
        st_d.stuck_code  = ERR_EMPTY;
      end else if (st_d.in_quotes && !st_d.quote_pending) begin
        st_d.error_stuck = 1'b1;
        st_d.stuck_code  = ERR_OPEN_QUOTE;
      end else if (st_d.quote_pending || st_d.after_quote || st_d.record_open) begin
        fe = 1'b1;
        re = 1'b1;
      end
    end

    if (st_d.error_stuck || !cv) begin
      cv = cv && !st_d.error_stuck;
      cb = 8'd0;
    end
    if (st_d.error_stuck) begin
      fe = 1'b0;
      re = 1'b0;
    end

    fl = st_q.start_line;
    fc = st_q.start_col;
    el = st_d.cur_line;
    ec = st_d.cur_col;

    result_o.content_valid = cv;
    result_o.content_byte  = cb;
    result_o.field_end     = fe;
    result_o.record_end    = re;
    result_o.doc_done      = item_i.doc_last;
    result_o.error_code    = st_d.error_stuck ? st_d.stuck_code : ERR_NONE;

    // Positions leave the block as their low 24 bits
    result_o.field_line    = OutPosBits'(fl);
    result_o.field_column  = OutPosBits'(fc);
    result_o.error_line    = OutPosBits'(el);
    result_o.error_column  = OutPosBits'(ec);

    if (item_i.doc_last) st_d = StateReset;
  end

endmodule
